@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the matrix multiply top level
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define IMM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked property that also holds during reset
`define IMM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/imm_pkg.sv @@
// ----------------------------------------------------------------------------
// imm_pkg
// Types and constants of the integer matrix multiply unit
// ----------------------------------------------------------------------------
package imm_pkg;

  // field widths
  localparam int IDX_W  = 3;
  localparam int DIM_W  = 4;
  localparam int DATA_W = 32;
  localparam int CFG_IDX_W = 2;

  // input item actions, code 3 does nothing
  typedef enum logic [1:0] {
    ACT_WRITE_A = 2'd0,
    ACT_WRITE_B = 2'd1,
    ACT_START   = 2'd2
  } imm_action_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd3;

  // control that travels with one multiply-accumulate step
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic             last_all;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } imm_tag_t;

  // zero is used as one, values above the bound as the bound
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = 4'd1;
    end else if (v > max_v) begin
      r = max_v;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ sv/imm_mac.sv @@
// ----------------------------------------------------------------------------
// imm_mac
// Registered multiply, wrapping accumulate and result register
// ----------------------------------------------------------------------------
module imm_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  imm_pkg::imm_tag_t                  tag_i,
  input  logic [imm_pkg::DATA_W-1:0]         a_i,
  input  logic [imm_pkg::DATA_W-1:0]         b_i,
  output logic                               active,
  output logic                               out_valid,
  output logic [imm_pkg::IDX_W-1:0]          out_row,
  output logic [imm_pkg::IDX_W-1:0]          out_col,
  output logic signed [imm_pkg::DATA_W-1:0]  out_value,
  output logic                               out_last
);
  import imm_pkg::*;

  imm_tag_t          tag2_r;
  logic [DATA_W-1:0] prod_r;
  logic [DATA_W-1:0] prod_nxt;
  logic [DATA_W-1:0] acc_r;
  logic [DATA_W-1:0] acc_nxt;
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_row_r;
  logic [IDX_W-1:0]  out_col_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_last_r;

  // low word of the product is the same for signed and unsigned operands
  assign prod_nxt = a_i * b_i;

  // accumulate with wraparound, restart on the first term
  assign acc_nxt = tag2_r.first ? prod_r : acc_r + prod_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tag2_r      <= tag_i;
      out_valid_r <= tag2_r.valid && tag2_r.last_k;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (tag2_r.valid) begin
      acc_r <= acc_nxt;
    end
    if (tag2_r.valid && tag2_r.last_k) begin
      out_row_r   <= tag2_r.row;
      out_col_r   <= tag2_r.col;
      out_value_r <= acc_nxt;
      out_last_r  <= tag2_r.last_all;
    end
  end

  assign active    = tag2_r.valid;
  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = signed'(out_value_r);
  assign out_last  = out_last_r;

endmodule

@@ sv/integer_matrix_multiply_unit.sv @@
// Element writes do not raise busy, so one write word per cycle while not busy.
// A start runs the multiply-accumulate steps over the clamped dimensions, one
// pair of memory reads per cycle, and then drains the result pipeline.
// One result word is given per element of the product, after its last inner
// step; the receiver cannot stall the stream.
// Synchronous reset sets the dimensions to 3; the stores keep no reset value.
// ----------------------------------------------------------------------------
// integer_matrix_multiply_unit
// Signed matrix product A*B over element stores held in two memories
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_matrix_multiply_unit #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_action,
  input  logic [imm_pkg::IDX_W-1:0]           in_row,
  input  logic [imm_pkg::IDX_W-1:0]           in_col,
  input  logic signed [imm_pkg::DATA_W-1:0]   in_value,
  input  logic                                cfg_we,
  input  logic [imm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [imm_pkg::DIM_W-1:0]           cfg_data,
  output logic                                out_valid,
  output logic [imm_pkg::IDX_W-1:0]           out_row,
  output logic [imm_pkg::IDX_W-1:0]           out_col,
  output logic signed [imm_pkg::DATA_W-1:0]   out_value,
  output logic                                out_last
);
  import imm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
    logic [2*IDX_W-1:0] a;
    a = ({{IDX_W{1'b0}}, r} * (2*IDX_W)'(MAX_DIM)) + {{IDX_W{1'b0}}, c};
    return a[ADDR_W-1:0];
  endfunction

  logic [DIM_W-1:0]  rows_a_r;
  logic [DIM_W-1:0]  inner_dim_r;
  logic [DIM_W-1:0]  cols_b_r;
  logic [DIM_W-1:0]  r_dim;
  logic [DIM_W-1:0]  k_dim;
  logic [DIM_W-1:0]  c_dim;

  logic              running_r;
  logic [IDX_W-1:0]  i_r;
  logic [IDX_W-1:0]  j_r;
  logic [IDX_W-1:0]  k_r;
  logic              i_end;
  logic              j_end;
  logic              k_end;

  logic              accept;
  logic              in_range;
  logic              wr_a;
  logic              wr_b;
  logic              go;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;

  logic [DATA_W-1:0] store_a [DEPTH];
  logic [DATA_W-1:0] store_b [DEPTH];
  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;

  imm_tag_t          tag0;
  imm_tag_t          tag1_r;
  logic              mac_active;

  logic              k_in_bound;
  logic              at_last_pos;
  logic              mid_step;

  // effective dimensions
  assign r_dim = clamp_dim(rows_a_r, MAX_DIM_V);
  assign k_dim = clamp_dim(inner_dim_r, MAX_DIM_V);
  assign c_dim = clamp_dim(cols_b_r, MAX_DIM_V);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_RESET;
      inner_dim_r <= DIM_RESET;
      cols_b_r    <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_A:    rows_a_r    <= cfg_data;
        REG_INNER_DIM: inner_dim_r <= cfg_data;
        REG_COLS_B:    cols_b_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input word decode
  assign busy     = running_r || tag1_r.valid || mac_active;
  assign accept   = start && !busy;
  assign in_range = ({1'b0, in_row} < MAX_DIM_V) && ({1'b0, in_col} < MAX_DIM_V);
  assign wr_a     = accept && (in_action == ACT_WRITE_A) && in_range;
  assign wr_b     = accept && (in_action == ACT_WRITE_B) && in_range;
  assign go       = accept && (in_action == ACT_START);
  assign wr_addr  = addr_of(in_row, in_col);

  // loop position
  assign k_end = ({1'b0, k_r} == k_dim - 4'd1);
  assign j_end = ({1'b0, j_r} == c_dim - 4'd1);
  assign i_end = ({1'b0, i_r} == r_dim - 4'd1);

  // sequencer over rows, columns and the inner index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
    end else if (go) begin
      running_r <= 1'b1;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
    end else if (running_r) begin
      if (k_end) begin
        k_r <= '0;
        if (j_end) begin
          j_r <= '0;
          if (i_end) begin
            running_r <= 1'b0;
          end else begin
            i_r <= i_r + 3'd1;
          end
        end else begin
          j_r <= j_r + 3'd1;
        end
      end else begin
        k_r <= k_r + 3'd1;
      end
    end
  end

  // read addresses and the tag of the step being issued
  assign rd_addr_a = addr_of(i_r, k_r);
  assign rd_addr_b = addr_of(k_r, j_r);

  always_comb begin
    tag0.valid    = running_r;
    tag0.first    = (k_r == '0);
    tag0.last_k   = k_end;
    tag0.last_all = k_end && j_end && i_end;
    tag0.row      = i_r;
    tag0.col      = j_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
    end else begin
      tag1_r <= tag0;
    end
  end

  // element stores, registered read
  always_ff @(posedge clk) begin
    if (wr_a) begin
      store_a[wr_addr] <= in_value;
    end
    rd_a_r <= store_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      store_b[wr_addr] <= in_value;
    end
    rd_b_r <= store_b[rd_addr_b];
  end

  // multiply-accumulate and result word
  imm_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_i     (tag1_r),
    .a_i       (rd_a_r),
    .b_i       (rd_b_r),
    .active    (mac_active),
    .out_valid (out_valid),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (out_last)
  );

  // checks
  assign k_in_bound  = ({1'b0, k_r} < k_dim);
  assign at_last_pos = ({1'b0, out_row} == r_dim - 4'd1) &&
                       ({1'b0, out_col} == c_dim - 4'd1);
  assign mid_step    = tag1_r.valid && !tag1_r.first;

  `IMM_ASSERT(a_k_bound, clk, rst_n, running_r |-> k_in_bound, "inner index past dimension")
  `IMM_ASSERT(a_last_pos, clk, rst_n, (out_valid && out_last) |-> at_last_pos, "last word misplaced")
  `IMM_ASSERT(a_last_idle, clk, rst_n, (out_valid && out_last) |-> !busy, "busy at last word")
  `IMM_ASSERT(a_tag_chain, clk, rst_n, mid_step |-> $past(tag1_r.valid), "step without predecessor")

endmodule
